// File: sv/pcf_pkg.sv
// Package for the PNG container framer: sequencer states, fixed chunk bytes,
// byte positions of the header and trailer runs, and the byte-wide CRC-32 step.
// No dependencies.
package pcf_pkg;

    // Default width of the payload byte counter
    localparam int LENGTH_BITS_DEF = 24;

    // Register map (register index = paddr[3:2])
    localparam int          ADDR_BITS    = 4;
    localparam logic [1:0]  REG_WIDTH    = 2'd0;
    localparam logic [1:0]  REG_HEIGHT   = 2'd1;
    localparam logic [1:0]  REG_COLOR    = 2'd2;
    localparam logic [1:0]  REG_LENGTH   = 2'd3;

    // Reset values of the registers
    localparam logic [15:0] WIDTH_RST    = 16'd1;
    localparam logic [15:0] HEIGHT_RST   = 16'd1;
    localparam logic [1:0]  COLOR_RST    = 2'd0;
    localparam logic [23:0] LENGTH_RST   = 24'd1;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    // Fixed bytes
    localparam logic [7:0]  IHDR_LEN     = 8'd13;
    localparam logic [7:0]  BIT_DEPTH    = 8'd8;
    localparam logic [7:0]  PNG_SIG   [8]  = '{8'd137, 8'd80, 8'd78, 8'd71,
                                              8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0]  IHDR_TYPE [4]  = '{8'd73, 8'd72, 8'd68, 8'd82};
    localparam logic [7:0]  IDAT_TYPE [4]  = '{8'd73, 8'd68, 8'd65, 8'd84};
    localparam logic [7:0]  IEND_CHUNK[12] = '{8'd0, 8'd0, 8'd0, 8'd0,
                                              8'd73, 8'd69, 8'd78, 8'd68,
                                              8'hAE, 8'h42, 8'h60, 8'h82};

    // Byte positions within the header run (signature .. IDAT type)
    localparam logic [5:0]  POS_IHDR_LEN  = 6'd11;
    localparam logic [5:0]  POS_IHDR_TYPE = 6'd12;
    localparam logic [5:0]  POS_WIDTH_HI  = 6'd18;
    localparam logic [5:0]  POS_WIDTH_LO  = 6'd19;
    localparam logic [5:0]  POS_HEIGHT_HI = 6'd22;
    localparam logic [5:0]  POS_HEIGHT_LO = 6'd23;
    localparam logic [5:0]  POS_DEPTH     = 6'd24;
    localparam logic [5:0]  POS_COLOR     = 6'd25;
    localparam logic [5:0]  POS_IHDR_CRC  = 6'd29;
    localparam logic [5:0]  POS_IDAT_LEN  = 6'd33;
    localparam logic [5:0]  POS_IDAT_TYPE = 6'd37;
    localparam logic [5:0]  HEAD_LAST     = 6'd40;
    // Trailer run: IDAT CRC then IEND
    localparam logic [5:0]  POS_IEND      = 6'd4;
    localparam logic [5:0]  TAIL_LAST     = 6'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DATA,
        ST_TAIL
    } t_state;

    // One byte folded into the CRC register, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Byte k of a 32-bit word, most significant first
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: sv/png_container_framer.sv
// PNG container framer: wraps a zlib byte stream into a PNG file with one IDAT chunk.
// Uses pcf_pkg (states, fixed chunk bytes, CRC step). Byte sequencer plus one
// shared byte-wide CRC unit that serves both the IHDR and the IDAT checksums.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+------------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata = data_byte
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata = out_byte, tlast = run_last,
//            |     |                              | tuser = file_end
//  apb       | in  | psel/penable/pwrite, pready=1 | width, height, color, length
//
// One file byte leaves per cycle within a run while the output is taken. An item is
// accepted only in idle, then sends its run: header (first byte of a file), payload
// byte, trailer (last byte of a file); the rate is set by the single output byte
// register and the byte-wide CRC unit, which each handle one byte per cycle.
// Reset (synchronous, active low) clears the count, loads the CRC with all ones
// and the registers with their defaults. A stalled output holds the sequencer.
module png_container_framer #(
    parameter int LENGTH_BITS = pcf_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] data_byte
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,   // [7:0] out_byte
    output logic                           o_m_axis_tlast,   // run_last
    output logic                           o_m_axis_tuser,   // [0] file_end
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcf_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    pcf_pkg::t_state r_state, n_state;

    logic [5:0]             r_pos, n_pos;
    logic [7:0]             r_data;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [31:0]            r_crc, n_crc;
    logic [15:0]            r_width, r_height;
    logic [1:0]             r_color;
    logic [23:0]            r_len;
    logic                   r_ovalid;
    logic [7:0]             r_obyte;
    logic                   r_olast, r_oend;

    logic                   w_adv;
    logic                   w_accept;
    logic                   w_cfg_wr;
    logic [1:0]             w_reg;
    logic [LENGTH_BITS-1:0] w_eff, w_cnt_inc;
    logic [31:0]            w_eff32;
    logic                   w_done;
    logic [7:0]             w_head_byte;
    logic                   w_emit, w_last, w_end;
    logic [7:0]             w_byte;

    // Handshakes
    assign w_adv    = !r_ovalid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == pcf_pkg::ST_IDLE);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oend;

    // Configuration port
    assign pready   = 1'b1;
    assign w_reg    = paddr[3:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg)
            pcf_pkg::REG_WIDTH:  prdata = {16'd0, r_width};
            pcf_pkg::REG_HEIGHT: prdata = {16'd0, r_height};
            pcf_pkg::REG_COLOR:  prdata = {30'd0, r_color};
            default:             prdata = {8'd0, r_len};
        endcase
    end

    // Effective length: masked to the counter width, zero read as one
    always_comb begin
        w_eff = LENGTH_BITS'(r_len);
        if (w_eff == '0) begin
            w_eff = LENGTH_BITS'(1);
        end
    end
    assign w_eff32   = 32'(w_eff);
    assign w_cnt_inc = r_cnt + LENGTH_BITS'(1);
    assign w_done    = (w_cnt_inc == '0) || (w_cnt_inc >= w_eff);

    // Header byte at the current position
    always_comb begin
        case (r_pos) inside
            [6'd0:6'd7]:   w_head_byte = pcf_pkg::PNG_SIG[3'(r_pos)];
            pcf_pkg::POS_IHDR_LEN: w_head_byte = pcf_pkg::IHDR_LEN;
            [6'd12:6'd15]: w_head_byte =
                               pcf_pkg::IHDR_TYPE[2'(r_pos - pcf_pkg::POS_IHDR_TYPE)];
            pcf_pkg::POS_WIDTH_HI:  w_head_byte = r_width[15:8];
            pcf_pkg::POS_WIDTH_LO:  w_head_byte = r_width[7:0];
            pcf_pkg::POS_HEIGHT_HI: w_head_byte = r_height[15:8];
            pcf_pkg::POS_HEIGHT_LO: w_head_byte = r_height[7:0];
            pcf_pkg::POS_DEPTH:     w_head_byte = pcf_pkg::BIT_DEPTH;
            pcf_pkg::POS_COLOR:     w_head_byte = {6'd0, r_color};
            [6'd29:6'd32]: w_head_byte =
                               pcf_pkg::be_byte(~r_crc, 2'(r_pos - pcf_pkg::POS_IHDR_CRC));
            [6'd33:6'd36]: w_head_byte =
                               pcf_pkg::be_byte(w_eff32, 2'(r_pos - pcf_pkg::POS_IDAT_LEN));
            [6'd37:6'd40]: w_head_byte =
                               pcf_pkg::IDAT_TYPE[2'(r_pos - pcf_pkg::POS_IDAT_TYPE)];
            default:       w_head_byte = 8'd0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (r_cnt == '0) ? pcf_pkg::ST_HEAD : pcf_pkg::ST_DATA;
                end
            end
            pcf_pkg::ST_HEAD: begin
                if (w_adv && r_pos == pcf_pkg::HEAD_LAST) begin
                    n_state = pcf_pkg::ST_DATA;
                end
            end
            pcf_pkg::ST_DATA: begin
                if (w_adv) begin
                    n_state = w_done ? pcf_pkg::ST_TAIL : pcf_pkg::ST_IDLE;
                end
            end
            pcf_pkg::ST_TAIL: begin
                if (w_adv && r_pos == pcf_pkg::TAIL_LAST) begin
                    n_state = pcf_pkg::ST_IDLE;
                end
            end
            default: n_state = pcf_pkg::ST_IDLE;
        endcase
    end

    // Byte selection, CRC unit and counter updates
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        w_emit = 1'b0;
        w_byte = 8'd0;
        w_last = 1'b0;
        w_end  = 1'b0;
        case (r_state)
            pcf_pkg::ST_IDLE: begin
                n_pos = '0;
            end
            pcf_pkg::ST_HEAD: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = w_head_byte;
                    n_pos  = (r_pos == pcf_pkg::HEAD_LAST) ? 6'd0 : r_pos + 6'd1;
                    // IHDR type and data, then IDAT type, go through the CRC
                    if (r_pos inside {[6'd12:6'd28], [6'd37:6'd40]}) begin
                        n_crc = pcf_pkg::crc_byte(r_crc, w_head_byte);
                    end else if (r_pos == pcf_pkg::POS_IDAT_LEN) begin
                        n_crc = pcf_pkg::CRC_INIT;
                    end
                end
            end
            pcf_pkg::ST_DATA: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = r_data;
                    w_last = !w_done;
                    n_crc  = pcf_pkg::crc_byte(r_crc, r_data);
                    n_cnt  = w_done ? '0 : w_cnt_inc;
                    n_pos  = '0;
                end
            end
            pcf_pkg::ST_TAIL: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    n_pos  = r_pos + 6'd1;
                    if (r_pos < pcf_pkg::POS_IEND) begin
                        w_byte = pcf_pkg::be_byte(~r_crc, 2'(r_pos));
                    end else begin
                        w_byte = pcf_pkg::IEND_CHUNK[4'(r_pos - pcf_pkg::POS_IEND)];
                    end
                    if (r_pos == pcf_pkg::TAIL_LAST) begin
                        w_last = 1'b1;
                        w_end  = 1'b1;
                        n_crc  = pcf_pkg::CRC_INIT;
                        n_pos  = '0;
                    end
                end
            end
            default: n_pos = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pcf_pkg::ST_IDLE;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_crc    <= pcf_pkg::CRC_INIT;
            r_ovalid <= 1'b0;
            r_width  <= pcf_pkg::WIDTH_RST;
            r_height <= pcf_pkg::HEIGHT_RST;
            r_color  <= pcf_pkg::COLOR_RST;
            r_len    <= pcf_pkg::LENGTH_RST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            if (w_adv) begin
                r_ovalid <= w_emit;
            end
            if (w_cfg_wr) begin
                case (w_reg)
                    pcf_pkg::REG_WIDTH:  r_width  <= pwdata[15:0];
                    pcf_pkg::REG_HEIGHT: r_height <= pwdata[15:0];
                    pcf_pkg::REG_COLOR:  r_color  <= pwdata[1:0];
                    default:             r_len    <= pwdata[23:0];
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_s_axis_tdata;
        end
        if (w_adv) begin
            r_obyte <= w_byte;
            r_olast <= w_last;
            r_oend  <= w_end;
        end
    end

endmodule

// File: sv/pcf_chk.sv
// Port-level checker for the PNG container framer, bound to the top level.
// Depends on png_container_framer's port list.
module pcf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // End of file only on the last byte of an item's run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("file end without run end");

    // Ready again only once the previous run is down to its last byte
    a_ready_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready && o_m_axis_tvalid |-> o_m_axis_tlast)
        else $error("input ready while a run is still pending");

    // An accepted item keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accept");

    // A stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("stalled output item changed");

endmodule

bind png_container_framer pcf_chk u_pcf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: tb/tb_png_container_framer.sv
// Testbench for png_container_framer: feeds zlib bytes, predicts every PNG file byte
// (signature, IHDR with CRC, IDAT framing and CRC, IEND) and checks the output stream.
// Depends on pcf_pkg (register indexes, address width) and the framer RTL.
module tb_png_container_framer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    // Fixed file bytes
    localparam logic [7:0] SIGNATURE [8]  = '{8'd137, 8'd80, 8'd78, 8'd71,
                                              8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0] IDAT_TAG  [4]  = '{8'h49, 8'h44, 8'h41, 8'h54};
    localparam logic [7:0] IEND_BYTES[12] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                              8'h49, 8'h45, 8'h4E, 8'h44,
                                              8'hAE, 8'h42, 8'h60, 8'h82};
    localparam logic [31:0] CRC_REFLECTED = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0] octet;
        logic       run_last;
        logic       file_end;
    } t_png_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        m_last;
    logic        m_user;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pcf_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    png_container_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores
    logic [7:0] zlib_bytes_pending[$];
    t_png_beat  png_bytes_due[$];
    logic [7:0] file_run[$];
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         feed_gap = 0;
    int         take_gap = 0;
    bit         jitter_on = 1'b1;
    bit         byte_in_fire = 1'b0;
    bit         byte_out_fire = 1'b0;

    // Framer state as the predictor sees it
    logic [15:0] cfg_width = 16'd1;
    logic [15:0] cfg_height = 16'd1;
    logic [1:0]  cfg_color = 2'd0;
    logic [23:0] cfg_length = 24'd1;
    logic [23:0] bytes_in_file = 24'd0;
    logic [31:0] idat_crc = 32'hFFFF_FFFF;

    task automatic report(input string what);
        if (mismatches < 50) $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Bit-serial reflected CRC-32, data bit i decides step i
    function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_REFLECTED : 32'd0);
        end
        return r;
    endfunction

    task automatic emit(input logic [7:0] b);
        file_run.push_back(b);
    endtask

    task automatic emit_word(input logic [31:0] w);
        emit(w[31:24]);
        emit(w[23:16]);
        emit(w[15:8]);
        emit(w[7:0]);
    endtask

    // Expected file bytes caused by one accepted payload byte
    task automatic frame_png_byte(input logic [7:0] d);
        logic [31:0] hcrc;
        logic [23:0] span;
        logic [7:0]  ihdr[17];
        logic        closes;
        t_png_beat   beat;
        span = (cfg_length == 24'd0) ? 24'd1 : cfg_length;
        closes = 1'b0;
        file_run.delete();
        // header run before the first payload byte of a file
        if (bytes_in_file == 24'd0) begin
            foreach (SIGNATURE[i]) emit(SIGNATURE[i]);
            emit_word(32'd13);
            ihdr = '{8'h49, 8'h48, 8'h44, 8'h52, 8'h00, 8'h00,
                     cfg_width[15:8], cfg_width[7:0], 8'h00, 8'h00,
                     cfg_height[15:8], cfg_height[7:0], 8'd8, {6'd0, cfg_color},
                     8'h00, 8'h00, 8'h00};
            hcrc = 32'hFFFF_FFFF;
            foreach (ihdr[i]) begin
                emit(ihdr[i]);
                hcrc = crc32_fold(hcrc, ihdr[i]);
            end
            emit_word(~hcrc);
            emit_word({8'd0, span});
            idat_crc = 32'hFFFF_FFFF;
            foreach (IDAT_TAG[i]) begin
                emit(IDAT_TAG[i]);
                idat_crc = crc32_fold(idat_crc, IDAT_TAG[i]);
            end
        end
        emit(d);
        idat_crc = crc32_fold(idat_crc, d);
        bytes_in_file = bytes_in_file + 24'd1;
        // trailer once the count reaches the current length (wrap also ends it)
        if (bytes_in_file == 24'd0 || bytes_in_file >= span) begin
            emit_word(~idat_crc);
            foreach (IEND_BYTES[i]) emit(IEND_BYTES[i]);
            closes = 1'b1;
            bytes_in_file = 24'd0;
            idat_crc = 32'hFFFF_FFFF;
        end
        foreach (file_run[i]) begin
            beat.octet = file_run[i];
            beat.run_last = (i == file_run.size() - 1);
            beat.file_end = closes && beat.run_last;
            png_bytes_due.push_back(beat);
        end
    endtask

    // Input driver: one item per handshake, random gaps while jitter is on
    always @(negedge i_clk) begin : feed
        logic       nv;
        logic [7:0] nd;
        nv = s_valid;
        nd = s_data;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_valid || byte_in_fire) begin
            nv = 1'b0;
            if (feed_gap > 0) begin
                feed_gap = feed_gap - 1;
            end else if (jitter_on && $urandom_range(0, 9) == 0) begin
                feed_gap = $urandom_range(0, 11);
            end else if (zlib_bytes_pending.size() != 0) begin
                nv = 1'b1;
                nd = zlib_bytes_pending.pop_front();
            end
        end
        s_valid <= nv;
        s_data <= nd;
    end

    // Output back-pressure
    always @(negedge i_clk) begin : drain
        logic nr;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (take_gap > 0) begin
            take_gap = take_gap - 1;
            nr = 1'b0;
        end else if (jitter_on && $urandom_range(0, 9) == 0) begin
            take_gap = $urandom_range(0, 11);
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        m_ready <= nr;
    end

    // Monitor: predict on input accept, then check output, then watchdog
    always @(posedge i_clk) begin : watch
        t_png_beat due;
        byte_in_fire = i_rst_n && s_valid && s_ready;
        byte_out_fire = i_rst_n && m_valid && m_ready;
        if (byte_in_fire) begin
            frame_png_byte(s_data);
            bytes_taken++;
        end
        if (byte_out_fire) begin
            if (png_bytes_due.size() == 0) begin
                report($sformatf("unexpected byte %02h", m_data));
            end else begin
                due = png_bytes_due.pop_front();
                if (m_data !== due.octet)
                    report($sformatf("out_byte %02h, want %02h", m_data, due.octet));
                if (m_last !== due.run_last)
                    report($sformatf("run_last %b, want %b", m_last, due.run_last));
                if (m_user !== due.file_end)
                    report($sformatf("file_end %b, want %b", m_user, due.file_end));
            end
        end
        quiet_cycles = (byte_in_fire || byte_out_fire) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // APB write, then read back and compare
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pcf_pkg::REG_WIDTH: begin
                cfg_width = value[15:0];
                want = {16'd0, value[15:0]};
            end
            pcf_pkg::REG_HEIGHT: begin
                cfg_height = value[15:0];
                want = {16'd0, value[15:0]};
            end
            pcf_pkg::REG_COLOR: begin
                cfg_color = value[1:0];
                want = {30'd0, value[1:0]};
            end
            default: begin
                cfg_length = value[23:0];
                want = {8'd0, value[23:0]};
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report($sformatf("reg %0d reads %08h, want %08h", idx, prdata, want));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic offer(input logic [7:0] b);
        zlib_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    // Sender holds off until every expected byte has been taken
    task automatic settle();
        while (bytes_taken != bytes_queued || png_bytes_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int          pick;
        logic [23:0] len;
        logic [31:0] top;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One-byte file on reset defaults
        offer(8'h00);
        settle();
        // Largest geometry, RGB, three-byte file
        set_reg(pcf_pkg::REG_WIDTH, 32'h0000_FFFF);
        set_reg(pcf_pkg::REG_HEIGHT, 32'hFFFF_FFFF);
        set_reg(pcf_pkg::REG_COLOR, 32'd2);
        set_reg(pcf_pkg::REG_LENGTH, 32'd3);
        offer(8'hFF);
        offer(8'h5A);
        offer(8'hA5);
        settle();
        // Zero length acts as one; odd color types go into IHDR as written
        set_reg(pcf_pkg::REG_LENGTH, 32'hFF00_0000);
        set_reg(pcf_pkg::REG_COLOR, 32'd3);
        offer(8'h00);
        settle();
        set_reg(pcf_pkg::REG_COLOR, 32'hFFFF_FFFD);
        offer(8'h80);
        settle();
        // Geometry and length changed in the middle of a file
        set_reg(pcf_pkg::REG_LENGTH, 32'd5);
        offer(8'h11);
        offer(8'h22);
        settle();
        set_reg(pcf_pkg::REG_WIDTH, 32'h0000_1234);
        set_reg(pcf_pkg::REG_HEIGHT, 32'h0000_0000);
        set_reg(pcf_pkg::REG_LENGTH, 32'd2);
        offer(8'h33);
        settle();
        // Longest length, then cut short on the fly
        set_reg(pcf_pkg::REG_LENGTH, 32'h00FF_FFFF);
        offer(8'h01);
        offer(8'h7F);
        offer(8'hFE);
        settle();
        set_reg(pcf_pkg::REG_LENGTH, 32'd4);
        offer(8'h77);
        settle();

        // Random phases; lengths mostly short so files close often
        for (int p = 0; p < 12; p++) begin
            jitter_on = (p < 9) && (p % 3 != 2);
            set_reg(pcf_pkg::REG_WIDTH, $urandom);
            set_reg(pcf_pkg::REG_HEIGHT, $urandom);
            set_reg(pcf_pkg::REG_COLOR, $urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0) len = 24'd0;
            else if (pick == 1) len = 24'hFF_FFFF;
            else if (pick == 2) len = 24'($urandom_range(13, 4000));
            else len = 24'($urandom_range(1, 12));
            top = $urandom;
            set_reg(pcf_pkg::REG_LENGTH, {top[7:0], len});
            repeat (30) offer(8'($urandom));
            settle();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/pcf_pkg.sv
sv/png_container_framer.sv
sv/pcf_chk.sv
tb/tb_png_container_framer.sv
